// ===== hw/rtl/qoi_pkg.sv =====
// ----------------------------------------------------------------------------
// QOI encoder package
// Shared widths, chunk opcodes and the chunk descriptor passed to the
// byte serializer.
// ----------------------------------------------------------------------------
package qoi_pkg;

    localparam int SideW  = 15;
    localparam int CountW = 28;
    localparam int SlotW  = 6;
    localparam int IdxDepth = 64;
    localparam int BodyMax = 5;

    localparam logic [5:0] RunCap = 6'd62;

    localparam logic [1:0] TagIndex = 2'b00;
    localparam logic [1:0] TagDiff  = 2'b01;
    localparam logic [1:0] TagLuma  = 2'b10;
    localparam logic [1:0] TagRun   = 2'b11;
    localparam logic [7:0] OpRgb    = 8'hFE;
    localparam logic [7:0] OpRgba   = 8'hFF;

    localparam logic [7:0] Magic0 = 8'h71;
    localparam logic [7:0] Magic1 = 8'h6F;
    localparam logic [7:0] Magic2 = 8'h69;
    localparam logic [7:0] Magic3 = 8'h66;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_CHAN   = 2'd2,
        CFG_CSPACE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                    hdr;
        logic [SideW-1:0]        w;
        logic [SideW-1:0]        h;
        logic                    ch4;
        logic                    cs;
        logic                    run;
        logic [7:0]              run_byte;
        logic [2:0]              cnt;
        logic [BodyMax-1:0][7:0] body;
        logic                    pad;
    } t_desc;

endpackage

// ===== hw/rtl/qoi_index.sv =====
// ----------------------------------------------------------------------------
// QOI color index
// 64-entry pixel memory with a registered read, write-to-read forwarding
// and per-entry valid bits that clear all at once.
// ----------------------------------------------------------------------------
module qoi_index import qoi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [SlotW-1:0] i_rd_addr,
    input  logic             i_wr_en,
    input  logic [SlotW-1:0] i_wr_addr,
    input  logic [31:0]      i_wr_data,
    input  logic             i_clear,
    input  logic [SlotW-1:0] i_slot,
    output logic [31:0]      o_entry
);

    logic [31:0]         r_mem [IdxDepth];
    logic [31:0]         r_q;
    logic [IdxDepth-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_q <= i_wr_data;
            end else begin
                r_q <= r_mem[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_entry = r_vld[i_slot] ? r_q : 32'd0;

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> (r_vld == '0))
        else $error("index not empty after clear");

    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && !i_clear) |=> r_vld[$past(i_wr_addr)])
        else $error("written entry not marked valid");

    a_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en && i_wr_en && (i_wr_addr == i_rd_addr)) |=> (r_q == $past(i_wr_data)))
        else $error("read missed same-cycle write");

endmodule

// ===== hw/rtl/qoi_ser.sv =====
// ----------------------------------------------------------------------------
// QOI byte serializer
// Holds one chunk descriptor and sends its header, run, chunk and padding
// bytes one beat at a time.
// ----------------------------------------------------------------------------
module qoi_ser import qoi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_desc      i_desc,
    output logic       o_free,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_item,
    output logic       o_end_of_image
);

    typedef enum logic [3:0] {
        PH_HDR  = 4'b0001,
        PH_RUN  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_PAD  = 4'b1000
    } t_phase;

    localparam logic [3:0] HdrEnd = 4'd13;
    localparam logic [3:0] PadEnd = 4'd7;

    function automatic t_phase pick(logic hdr, logic run, logic body);
        t_phase p;
        if (hdr) begin
            p = PH_HDR;
        end else if (run) begin
            p = PH_RUN;
        end else if (body) begin
            p = PH_BODY;
        end else begin
            p = PH_PAD;
        end
        return p;
    endfunction

    t_desc      r_desc;
    logic       r_valid;
    t_phase     r_phase;
    logic [3:0] r_cnt;

    logic       beat;
    logic       phase_end;
    logic       more;
    logic       last;
    t_phase     nxt;
    logic       has_body;
    logic [7:0] byte_out;

    assign has_body = (r_desc.cnt != 3'd0);

    always_comb begin
        phase_end = 1'b0;
        more      = 1'b0;
        nxt       = PH_PAD;
        case (r_phase)
            PH_HDR: begin
                phase_end = (r_cnt == HdrEnd);
                more      = r_desc.run || has_body || r_desc.pad;
                nxt       = pick(1'b0, r_desc.run, has_body);
            end
            PH_RUN: begin
                phase_end = 1'b1;
                more      = has_body || r_desc.pad;
                nxt       = pick(1'b0, 1'b0, has_body);
            end
            PH_BODY: begin
                phase_end = (r_cnt[2:0] == (r_desc.cnt - 3'd1));
                more      = r_desc.pad;
                nxt       = PH_PAD;
            end
            PH_PAD: begin
                phase_end = (r_cnt == PadEnd);
                more      = 1'b0;
                nxt       = PH_PAD;
            end
            default: begin
                phase_end = 1'b1;
                more      = 1'b0;
                nxt       = PH_PAD;
            end
        endcase
    end

    assign last   = phase_end && !more;
    assign beat   = r_valid && !i_out_stall;
    assign o_free = !r_valid || (beat && last);

    always_comb begin
        byte_out = 8'd0;
        case (r_phase)
            PH_HDR: begin
                case (r_cnt)
                    4'd0:    byte_out = Magic0;
                    4'd1:    byte_out = Magic1;
                    4'd2:    byte_out = Magic2;
                    4'd3:    byte_out = Magic3;
                    4'd6:    byte_out = {1'b0, r_desc.w[14:8]};
                    4'd7:    byte_out = r_desc.w[7:0];
                    4'd10:   byte_out = {1'b0, r_desc.h[14:8]};
                    4'd11:   byte_out = r_desc.h[7:0];
                    4'd12:   byte_out = r_desc.ch4 ? 8'd4 : 8'd3;
                    4'd13:   byte_out = {7'd0, r_desc.cs};
                    default: byte_out = 8'd0;
                endcase
            end
            PH_RUN:  byte_out = r_desc.run_byte;
            PH_BODY: byte_out = r_desc.body[r_cnt[2:0]];
            PH_PAD:  byte_out = {7'd0, (r_cnt == PadEnd)};
            default: byte_out = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= PH_HDR;
            r_cnt   <= 4'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_phase <= pick(i_desc.hdr, i_desc.run, (i_desc.cnt != 3'd0));
            r_cnt   <= 4'd0;
        end else if (beat) begin
            if (last) begin
                r_valid <= 1'b0;
            end else if (phase_end) begin
                r_phase <= nxt;
                r_cnt   <= 4'd0;
            end else begin
                r_cnt   <= r_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc <= i_desc;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_out_byte     = byte_out;
    assign o_last_of_item = last;
    assign o_end_of_image = (r_phase == PH_PAD) && (r_cnt == PadEnd);

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_end_of_image) |-> (last && r_desc.pad))
        else $error("end of image not on final beat");

    a_hdr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_phase == PH_HDR)) |-> r_desc.hdr)
        else $error("header sent for pixel without header");

endmodule

// ===== hw/rtl/qoi_image_encoder.sv =====
// ----------------------------------------------------------------------------
// QOI image encoder
// Encodes one RGBA pixel per beat into the QOI byte stream.
// ----------------------------------------------------------------------------
// Pixels enter on the input channel (i_in_valid, o_in_stall) and bytes leave
// on the output channel (o_out_valid, i_out_stall), one byte per beat, with
// o_last_of_item on the final byte caused by a pixel and o_end_of_image on
// the final padding byte. The user must set image size, channel count and
// color space through the configuration port only while the encoder is idle;
// the encoder does not enforce this. A pixel is registered at acceptance and
// encoded, once the serializer is free, into a descriptor that it registers.
// A new pixel is taken every cycle while the receiver does not stall and each
// pixel yields at most one byte; else the serializer sends its bytes (header
// 14, chunk up to 6, padding 8) one per beat while the next pixel waits.
// When the receiver stalls, the output byte holds and the input stalls once
// the input register and the descriptor register are both full.
// Reset loads the default configuration, clears the color index, the run
// and the pixel counter; the next pixel starts a new image with its header.
// ----------------------------------------------------------------------------
module qoi_image_encoder import qoi_pkg::*; #(
    parameter int MAX_SIDE = 16384
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    input  logic [7:0]       i_alpha,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_item,
    output logic             o_end_of_image,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [SideW-1:0] i_cfg_data
);

    localparam logic [SideW-1:0] MaxSide = SideW'(MAX_SIDE);

    function automatic logic [SlotW-1:0] qoi_hash(logic [31:0] px);
        logic [SlotW-1:0] s;
        s = px[29:24] * 6'd3 + px[21:16] * 6'd5 + px[13:8] * 6'd7 + px[5:0] * 6'd11;
        return s;
    endfunction

    function automatic logic [SideW-1:0] side_used(logic [SideW-1:0] v);
        logic [SideW-1:0] s;
        if (v == '0) begin
            s = SideW'(1);
        end else if (v > MaxSide) begin
            s = MaxSide;
        end else begin
            s = v;
        end
        return s;
    endfunction

    logic [SideW-1:0]  r_width;
    logic [SideW-1:0]  r_height;
    logic [2:0]        r_chan;
    logic              r_cspace;
    logic [CountW-1:0] r_last_pos;

    logic [SideW-1:0]   w_used;
    logic [SideW-1:0]   h_used;
    logic               ch4;
    logic [2*SideW-1:0] area;

    logic              r_in_valid;
    logic [31:0]       r_px;
    logic [SlotW-1:0]  r_slot;
    logic [31:0]       r_prev;
    logic [5:0]        r_run;
    logic [CountW-1:0] r_cnt;

    logic [31:0]       n_prev;
    logic [5:0]        n_run;
    logic [CountW-1:0] n_cnt;

    logic              in_take;
    logic              proc_fire;
    logic              ser_free;
    logic [31:0]       in_px;
    logic [31:0]       idx_entry;
    logic              idx_wr;
    logic              idx_clr;
    t_desc             desc;
    logic              desc_any;

    logic              is_last;
    logic              same;
    logic              hit;
    logic [5:0]        run_nx;
    logic [7:0]        vr;
    logic [7:0]        vg;
    logic [7:0]        vb;
    logic [7:0]        vgr;
    logic [7:0]        vgb;
    logic [7:0]        tr;
    logic [7:0]        tg;
    logic [7:0]        tb;
    logic [7:0]        tl;
    logic [7:0]        tgr;
    logic [7:0]        tgb;
    logic              small_diff;
    logic              luma_fit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SideW'(1);
            r_height <= SideW'(1);
            r_chan   <= 3'd4;
            r_cspace <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_CHAN:   r_chan   <= i_cfg_data[2:0];
                CFG_CSPACE: r_cspace <= i_cfg_data[0];
                default:    r_cspace <= r_cspace;
            endcase
        end
    end

    assign w_used = side_used(r_width);
    assign h_used = side_used(r_height);
    assign ch4    = (r_chan != 3'd3);
    assign area   = w_used * h_used;

    always_ff @(posedge i_clk) begin
        r_last_pos <= CountW'(area - 30'd1);
    end

    assign in_px     = {i_red, i_green, i_blue, (ch4 ? i_alpha : 8'hFF)};
    assign proc_fire = r_in_valid && ser_free;
    assign o_in_stall = r_in_valid && !ser_free;
    assign in_take   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_px   <= in_px;
            r_slot <= qoi_hash(in_px);
        end
    end

    qoi_index u_index (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_take),
        .i_rd_addr (qoi_hash(in_px)),
        .i_wr_en   (idx_wr),
        .i_wr_addr (r_slot),
        .i_wr_data (r_px),
        .i_clear   (idx_clr),
        .i_slot    (r_slot),
        .o_entry   (idx_entry)
    );

    assign is_last = (r_cnt >= r_last_pos);
    assign same    = (r_px == r_prev);
    assign hit     = (idx_entry == r_px);
    assign run_nx  = r_run + 6'd1;

    assign vr  = r_px[31:24] - r_prev[31:24];
    assign vg  = r_px[23:16] - r_prev[23:16];
    assign vb  = r_px[15:8]  - r_prev[15:8];
    assign vgr = vr - vg;
    assign vgb = vb - vg;
    assign tr  = vr + 8'd2;
    assign tg  = vg + 8'd2;
    assign tb  = vb + 8'd2;
    assign tl  = vg + 8'd32;
    assign tgr = vgr + 8'd8;
    assign tgb = vgb + 8'd8;

    assign small_diff = ($signed(vr) >= -8'sd2) && ($signed(vr) <= 8'sd1)
                     && ($signed(vg) >= -8'sd2) && ($signed(vg) <= 8'sd1)
                     && ($signed(vb) >= -8'sd2) && ($signed(vb) <= 8'sd1);
    assign luma_fit   = ($signed(vgr) >= -8'sd8) && ($signed(vgr) <= 8'sd7)
                     && ($signed(vg) >= -8'sd32) && ($signed(vg) <= 8'sd31)
                     && ($signed(vgb) >= -8'sd8) && ($signed(vgb) <= 8'sd7);

    always_comb begin
        desc          = '0;
        desc.hdr      = (r_cnt == '0);
        desc.w        = w_used;
        desc.h        = h_used;
        desc.ch4      = ch4;
        desc.cs       = r_cspace;
        desc.pad      = is_last;
        idx_wr        = 1'b0;
        n_run         = 6'd0;
        if (same) begin
            desc.run      = (run_nx == RunCap) || is_last;
            desc.run_byte = {TagRun, r_run};
            n_run         = desc.run ? 6'd0 : run_nx;
        end else begin
            desc.run      = (r_run != 6'd0);
            desc.run_byte = {TagRun, r_run - 6'd1};
            if (hit) begin
                desc.body[0] = {TagIndex, r_slot};
                desc.cnt     = 3'd1;
            end else begin
                idx_wr = proc_fire;
                if (r_px[7:0] == r_prev[7:0]) begin
                    if (small_diff) begin
                        desc.body[0] = {TagDiff, tr[1:0], tg[1:0], tb[1:0]};
                        desc.cnt     = 3'd1;
                    end else if (luma_fit) begin
                        desc.body[0] = {TagLuma, tl[5:0]};
                        desc.body[1] = {tgr[3:0], tgb[3:0]};
                        desc.cnt     = 3'd2;
                    end else begin
                        desc.body[0] = OpRgb;
                        desc.body[1] = r_px[31:24];
                        desc.body[2] = r_px[23:16];
                        desc.body[3] = r_px[15:8];
                        desc.cnt     = 3'd4;
                    end
                end else begin
                    desc.body[0] = OpRgba;
                    desc.body[1] = r_px[31:24];
                    desc.body[2] = r_px[23:16];
                    desc.body[3] = r_px[15:8];
                    desc.body[4] = r_px[7:0];
                    desc.cnt     = 3'd5;
                end
            end
        end
        if (is_last) begin
            n_prev = 32'h0000_00FF;
            n_run  = 6'd0;
            n_cnt  = '0;
        end else begin
            n_prev = r_px;
            n_cnt  = r_cnt + CountW'(1);
        end
    end

    assign idx_clr  = proc_fire && is_last;
    assign desc_any = desc.hdr || desc.run || (desc.cnt != 3'd0) || desc.pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 32'h0000_00FF;
            r_run  <= 6'd0;
            r_cnt  <= '0;
        end else if (proc_fire) begin
            r_prev <= n_prev;
            r_run  <= n_run;
            r_cnt  <= n_cnt;
        end
    end

    qoi_ser u_ser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (proc_fire && desc_any),
        .i_desc         (desc),
        .o_free         (ser_free),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item),
        .o_end_of_image (o_end_of_image)
    );

endmodule

// ===== tb/sv/tb_qoi_image_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QOI image encoder testbench
// Sends pixels one per input beat and checks every output beat against a
// behavioral encoder, byte by byte, with random gaps on the pixel side and
// random stalls on the byte side. A directed opening covers each chunk kind,
// run flushing, ignored alpha and out-of-range register values, and random
// images with runs, small steps, index repeats and noise follow.
// ----------------------------------------------------------------------------
module tb_qoi_image_encoder;
    import qoi_pkg::*;

    localparam int MaxSide      = 16384;
    localparam int PixelTarget  = 310;
    localparam int SettleCycles = 8;
    localparam int CycleLimit   = 1_000_000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eoi;
    } t_beat;

    class QoiStreamChecker;
        logic [SideW-1:0]  width_cfg;
        logic [SideW-1:0]  height_cfg;
        logic [2:0]        chan_cfg;
        logic              cspace_cfg;
        logic [31:0]       palette [IdxDepth];
        logic [31:0]       prev_px;
        int unsigned       run_len;
        logic [CountW-1:0] pix_count;
        t_beat             pending_bytes [$];
        int unsigned       errors;
        int unsigned       pixels;
        int unsigned       images;
        int unsigned       bytes_checked;

        function new();
            width_cfg = 1;
            height_cfg = 1;
            chan_cfg = 4;
            cspace_cfg = 0;
            errors = 0;
            pixels = 0;
            images = 0;
            bytes_checked = 0;
            restart_image();
        endfunction

        function void restart_image();
            foreach (palette[i]) palette[i] = '0;
            prev_px = 32'h0000_00FF;
            run_len = 0;
            pix_count = '0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [SideW-1:0] val);
            case (idx)
                CFG_WIDTH:  width_cfg = val;
                CFG_HEIGHT: height_cfg = val;
                CFG_CHAN:   chan_cfg = val[2:0];
                CFG_CSPACE: cspace_cfg = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_side(logic [SideW-1:0] v);
            if (v == 0) return 1;
            if (v > MaxSide) return MaxSide;
            return v;
        endfunction

        function void add_byte(logic [7:0] b);
            t_beat nb;
            nb.data = b;
            nb.last = 1'b0;
            nb.eoi = 1'b0;
            pending_bytes.push_back(nb);
        endfunction

        function void add_word(logic [31:0] v);
            add_byte(v[31:24]);
            add_byte(v[23:16]);
            add_byte(v[15:8]);
            add_byte(v[7:0]);
        endfunction

        function void encode_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   logic [7:0] a_in);
            int unsigned w;
            int unsigned h;
            int unsigned slot;
            int          n_before;
            logic [2:0]  ch;
            logic [7:0]  a;
            logic [7:0]  pr;
            logic [7:0]  pg;
            logic [7:0]  pb;
            logic [7:0]  pa;
            logic [31:0] px;
            bit          is_last;
            byte         vr;
            byte         vg;
            byte         vb;
            byte         vgr;
            byte         vgb;

            n_before = pending_bytes.size();
            pixels++;
            w = clamp_side(width_cfg);
            h = clamp_side(height_cfg);
            ch = (chan_cfg == 3'd3) ? 3'd3 : 3'd4;
            is_last = (pix_count >= w * h - 1);
            a = (ch == 3'd3) ? 8'hFF : a_in;
            px = {r, g, b, a};

            if (pix_count == 0) begin
                add_word({Magic0, Magic1, Magic2, Magic3});
                add_word(w);
                add_word(h);
                add_byte({5'd0, ch});
                add_byte({7'd0, cspace_cfg});
            end

            if (px == prev_px) begin
                run_len++;
                if (run_len == RunCap || is_last) begin
                    add_byte({TagRun, 6'(run_len - 1)});
                    run_len = 0;
                end
            end else begin
                if (run_len > 0) begin
                    add_byte({TagRun, 6'(run_len - 1)});
                    run_len = 0;
                end
                slot = (r * 3 + g * 5 + b * 7 + a * 11) % IdxDepth;
                if (palette[slot] == px) begin
                    add_byte({TagIndex, 6'(slot)});
                end else begin
                    palette[slot] = px;
                    {pr, pg, pb, pa} = prev_px;
                    if (a == pa) begin
                        vr = r - pr;
                        vg = g - pg;
                        vb = b - pb;
                        vgr = vr - vg;
                        vgb = vb - vg;
                        if (vr >= -2 && vr <= 1 && vg >= -2 && vg <= 1 &&
                            vb >= -2 && vb <= 1) begin
                            add_byte({TagDiff, 2'(vr + 2), 2'(vg + 2), 2'(vb + 2)});
                        end else if (vgr >= -8 && vgr <= 7 && vg >= -32 && vg <= 31 &&
                                     vgb >= -8 && vgb <= 7) begin
                            add_byte({TagLuma, 6'(vg + 32)});
                            add_byte({4'(vgr + 8), 4'(vgb + 8)});
                        end else begin
                            add_byte(OpRgb);
                            add_byte(r);
                            add_byte(g);
                            add_byte(b);
                        end
                    end else begin
                        add_byte(OpRgba);
                        add_byte(r);
                        add_byte(g);
                        add_byte(b);
                        add_byte(a);
                    end
                end
            end
            prev_px = px;

            if (is_last) begin
                repeat (7) add_byte(8'h00);
                add_byte(8'h01);
                pending_bytes[pending_bytes.size() - 1].eoi = 1'b1;
                images++;
                restart_image();
            end else begin
                pix_count++;
            end

            if (pending_bytes.size() > n_before)
                pending_bytes[pending_bytes.size() - 1].last = 1'b1;
        endfunction

        function void check_byte(logic [7:0] data, logic last, logic eoi);
            t_beat want;
            bytes_checked++;
            if (pending_bytes.size() == 0) begin
                errors++;
                $display("%0t: byte %02h arrived with nothing expected", $time, data);
                return;
            end
            want = pending_bytes.pop_front();
            if (want.data !== data) begin
                errors++;
                $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
            end
            if (want.last !== last) begin
                errors++;
                $display("%0t: last_of_item expected %0b actual %0b", $time, want.last, last);
            end
            if (want.eoi !== eoi) begin
                errors++;
                $display("%0t: end_of_image expected %0b actual %0b", $time, want.eoi, eoi);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [7:0]       i_red = '0;
    logic [7:0]       i_green = '0;
    logic [7:0]       i_blue = '0;
    logic [7:0]       i_alpha = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [7:0]       o_out_byte;
    logic             o_last_of_item;
    logic             o_end_of_image;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index = '0;
    logic [SideW-1:0] i_cfg_data = '0;

    QoiStreamChecker board = new();
    int unsigned     cycle_count = 0;
    int unsigned     cfg_writes = 0;
    int unsigned     pixels_sent = 0;
    int              stall_left = 0;
    int              stall_pick;
    bit              quiet_phase = 1'b0;
    logic [31:0]     last_sent = 32'h0000_00FF;
    logic [31:0]     recent [8];
    int              recent_wr = 0;

    qoi_image_encoder #(.MAX_SIDE(MaxSide)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, board.pending_bytes.size());
            $display("tb_qoi_image_encoder: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_byte(o_out_byte, o_last_of_item, o_end_of_image);
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (i_out_stall) begin
                i_out_stall <= 1'b0;
                stall_left <= (stall_pick < 15) ? $urandom_range(80, 250)
                                                : $urandom_range(0, 4);
            end else begin
                i_out_stall <= 1'b1;
                stall_left <= (stall_pick < 8) ? $urandom_range(10, 24)
                                               : $urandom_range(0, 2);
            end
        end
    end

    function automatic int pick_gap();
        int p;
        if (quiet_phase) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 24);
    endfunction

    function automatic logic [31:0] vary_pixel(int kind, logic [31:0] base);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        int         dg;
        {r, g, b, a} = base;
        case (kind)
            0: begin
                r = r + 8'($urandom_range(0, 3)) - 8'd2;
                g = g + 8'($urandom_range(0, 3)) - 8'd2;
                b = b + 8'($urandom_range(0, 3)) - 8'd2;
            end
            1: begin
                dg = int'($urandom_range(0, 63)) - 32;
                g = g + 8'(dg);
                r = r + 8'(dg + int'($urandom_range(0, 15)) - 8);
                b = b + 8'(dg + int'($urandom_range(0, 15)) - 8);
            end
            2: {r, g, b, a} = recent[$urandom_range(0, 7)];
            3: {r, g, b} = 24'($urandom);
            4: {r, g, b, a} = $urandom;
            default: begin
                r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
        endcase
        return {r, g, b, a};
    endfunction

    task automatic drive_pixel(logic [31:0] px);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        {i_red, i_green, i_blue, i_alpha} <= px;
        do @(posedge i_clk); while (o_in_stall);
        board.encode_pixel(px[31:24], px[23:16], px[15:8], px[7:0]);
        last_sent = px;
        recent[recent_wr] = px;
        recent_wr = (recent_wr + 1) % 8;
        pixels_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= SideW'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, SideW'(val));
        cfg_writes++;
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned ch,
                             int unsigned cs);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_CHAN, ch);
        write_reg(CFG_CSPACE, cs);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int unsigned pick_side(int unsigned typical);
        int p;
        p = $urandom_range(0, 99);
        if (p < 82) return $urandom_range(1, typical);
        case ($urandom_range(0, 4))
            0: return 0;
            1: return MaxSide;
            2: return MaxSide + 1;
            3: return 32767;
            default: return $urandom_range(1, 32767);
        endcase
    endfunction

    initial begin
        int          kind;
        int          p;
        int          run;
        int          count;
        int          sent_here;
        int unsigned w;
        int unsigned h;
        int unsigned ch;
        int unsigned area;

        foreach (recent[i]) recent[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default setup is a single RGBA pixel per image.
        drive_pixel(32'h0000_00FF);
        drive_pixel(32'hFFFF_FF00);
        wait_idle();

        // Largest image with three channels, so alpha on the input is ignored.
        configure(MaxSide, MaxSide, 3, 1);
        drive_pixel(32'h0000_0012);
        drive_pixel(32'h0000_0034);
        drive_pixel(32'h0101_01AA);
        drive_pixel(32'hFF00_FF00);
        drive_pixel(32'h1F1F_1F00);
        drive_pixel(32'hC803_5A00);
        drive_pixel(32'h0101_0100);
        drive_pixel(32'hC803_5A00);
        drive_pixel(32'hC803_5A00);
        drive_pixel(32'hC803_5A00);
        drive_pixel(32'h0101_0100);
        wait_idle();

        // Switch to RGBA inside the same image and hit the step limits.
        configure(MaxSide, MaxSide, 4, 0);
        drive_pixel(32'h0101_0180);
        drive_pixel(32'hD9E1_E880);
        drive_pixel(32'hFF00_FF80);
        drive_pixel(32'h0001_FD80);
        drive_pixel(32'h0001_FD00);
        drive_pixel(32'h0101_0180);
        wait_idle();

        // Zero sides act as one, so the next pixel closes the open image.
        configure(0, 0, 7, 1);
        drive_pixel(32'h0101_0180);
        drive_pixel(32'h7F7F_7F7F);

        while (pixels_sent < PixelTarget) begin
            wait_idle();
            w = pick_side(8);
            h = pick_side(6);
            p = $urandom_range(0, 99);
            ch = (p < 45) ? 3 : (p < 90) ? 4 : $urandom_range(0, 7);
            configure(w, h, ch, $urandom_range(0, 1));
            quiet_phase = ($urandom_range(0, 3) == 0);
            area = board.clamp_side(SideW'(w)) * board.clamp_side(SideW'(h));
            if (area > 40) begin
                count = $urandom_range(10, 40);
            end else begin
                p = $urandom_range(0, 3);
                count = (p == 0) ? area + $urandom_range(1, area)
                      : (p == 1) ? $urandom_range(1, area) : area;
            end
            sent_here = 0;
            while (sent_here < count && pixels_sent < PixelTarget) begin
                p = $urandom_range(0, 99);
                if (p < 20) begin
                    run = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                       : $urandom_range(1, 5);
                    if (run > PixelTarget - int'(pixels_sent))
                        run = PixelTarget - int'(pixels_sent);
                    repeat (run) drive_pixel(last_sent);
                    sent_here += run;
                end else begin
                    kind = (p < 38) ? 0 : (p < 53) ? 1 : (p < 65) ? 2 :
                           (p < 80) ? 3 : (p < 92) ? 4 : 5;
                    drive_pixel(vary_pixel(kind, last_sent));
                    sent_here++;
                end
                if ($urandom_range(0, 39) == 0) wait_idle();
            end
        end

        wait_idle();
        $display("Encoded %0d pixels into %0d finished images; %0d bytes compared.",
                 board.pixels, board.images, board.bytes_checked);
        $display("Register writes: %0d, mismatches: %0d.", cfg_writes, board.errors);
        if (board.errors == 0) begin
            $display("tb_qoi_image_encoder: PASS");
        end else begin
            $display("tb_qoi_image_encoder: FAIL");
        end
        $finish;
    end

endmodule
